// File: rtl/hdlc_enc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hdlc_enc_pkg
// Shared types and constants for the HDLC NRZI bit-stuffing line encoder.
// ----------------------------------------------------------------------------
package hdlc_enc_pkg;

  // Item opcodes; code 3 is unused and the item is dropped.
  typedef enum logic [1:0] {
    OP_STUFFED = 2'd0,
    OP_PLAIN   = 2'd1,
    OP_MARK    = 2'd2,
    OP_UNUSED  = 2'd3
  } opcode_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_INVERT_TONES   = 2'd0,
    REG_BITS_PER_OCTET = 2'd1
  } reg_index_e;

  localparam int unsigned OctetBits = 8;
  localparam int unsigned MaxSyms   = 10;  // 8 bits plus up to 2 stuffed toggles
  localparam int unsigned SymCntW   = 4;

  localparam logic [2:0] StuffRun = 3'd5;
  localparam logic [2:0] RunMax   = 3'd7;

  localparam logic [3:0] BitsPerOctetRst = 4'd8;

endpackage : hdlc_enc_pkg
`default_nettype wire

// File: rtl/hdlc_nrzi_bit_stuff_encoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hdlc_nrzi_bit_stuff_encoder
// HDLC NRZI line encoder with optional bit stuffing, items in, symbols out one by one.
// ----------------------------------------------------------------------------
// Datapath: an item waits in the input register until the output shift
//   register is empty or emptying, then its symbols leave from there.
// Throughput: one symbol per cycle while out_stall_i is low; an item makes
//   1 symbol for a mark, bits_per_octet plus stuffed toggles, up to 10, for
//   an octet. The next item is expanded while the last symbol of the
//   previous one is taken, so items follow with no gap.
// Reset: asynchronous, active low; clears line level, ones run, both stages,
//   and loads invert_tones = 0, bits_per_octet = 8.
// ----------------------------------------------------------------------------
module hdlc_nrzi_bit_stuff_encoder
  import hdlc_enc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // configuration write port
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [3:0] cfg_data_i,
  // input items
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] opcode_i,
  input  wire logic [7:0] octet_i,
  // output symbols
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            symbol_o,
  output logic            last_o
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic       invert_q;
  logic [3:0] bpo_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q <= 1'b0;
      bpo_q    <= BitsPerOctetRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_INVERT_TONES:   invert_q <= cfg_data_i[0];
        REG_BITS_PER_OCTET: bpo_q    <= cfg_data_i;
        default:            ;  // no register there
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic       in_vld_q;
  logic [1:0] op_q;
  logic [7:0] octet_q;
  logic       advance;   // item leaves the input register this cycle
  logic       load;      // expanded symbols go into the shift register
  logic       sink_free; // shift register empty or emptying now

  // Output shift register
  logic [MaxSyms-1:0] syms_q;
  logic [SymCntW-1:0] cnt_q;
  logic               out_take;

  assign out_take  = out_valid_o && !out_stall_i;
  assign sink_free = (cnt_q == '0) || ((cnt_q == SymCntW'(1)) && out_take);

  // An unused opcode is dropped without waiting for the output side.
  assign advance    = in_vld_q && ((op_q == OP_UNUSED) || sink_free);
  assign load       = advance && (op_q != OP_UNUSED);
  assign in_stall_o = in_vld_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      op_q    <= opcode_i;
      octet_q <= octet_i;
    end
  end

  // --------------------------------------------------------------------------
  // Expansion: octet bits LSB first into NRZI symbols, with stuffing
  // --------------------------------------------------------------------------
  logic               level_q;
  logic [2:0]         run_q;
  logic               level_d;
  logic [2:0]         run_d;
  logic [MaxSyms-1:0] syms_d;
  logic [SymCntW-1:0] cnt_d;
  logic [3:0]         nbits;

  // bits_per_octet clamps to 1..8
  always_comb begin
    if (bpo_q == 4'd0) begin
      nbits = 4'd1;
    end else if (bpo_q > 4'd8) begin
      nbits = 4'd8;
    end else begin
      nbits = bpo_q;
    end
  end

  always_comb begin
    logic               lvl;
    logic [2:0]         run;
    logic [SymCntW-1:0] pos;
    logic [MaxSyms-1:0] sv;
    logic               stuff;
    lvl   = level_q;
    run   = run_q;
    pos   = '0;
    sv    = '0;
    stuff = (op_q == OP_STUFFED);
    if (op_q == OP_MARK) begin
      // raw mark: a single low-tone symbol, line state untouched
      sv[0] = invert_q;
      pos   = SymCntW'(1);
    end else begin
      for (int i = 0; i < OctetBits; i++) begin
        if (4'(i) < nbits) begin
          if (!octet_q[i]) begin
            lvl     = ~lvl;
            sv[pos] = lvl ^ invert_q;
            pos     = pos + SymCntW'(1);
            run     = '0;
          end else begin
            sv[pos] = lvl ^ invert_q;
            pos     = pos + SymCntW'(1);
            if (run != RunMax) begin
              run = run + 3'd1;
            end
            if ((run == StuffRun) && stuff) begin
              lvl     = ~lvl;
              sv[pos] = lvl ^ invert_q;
              pos     = pos + SymCntW'(1);
              run     = '0;
            end
          end
        end
      end
    end
    level_d = lvl;
    run_d   = run;
    syms_d  = sv;
    cnt_d   = pos;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= 1'b0;
      run_q   <= '0;
    end else if (load) begin
      level_q <= level_d;
      run_q   <= run_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output shift register: symbol in bit 0, remaining count in cnt_q
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load) begin
      cnt_q <= cnt_d;
    end else if (out_take) begin
      cnt_q <= cnt_q - SymCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      syms_q <= syms_d;
    end else if (out_take) begin
      syms_q <= {1'b0, syms_q[MaxSyms-1:1]};
    end
  end

  assign out_valid_o = (cnt_q != '0);
  assign symbol_o    = syms_q[0];
  assign last_o      = (cnt_q == SymCntW'(1));

`ifndef ASSERT_OFF
  // a loaded item always shows a symbol next cycle
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_o)
    else $error("loaded item produced no symbol");

  // never more symbols pending than one item can make
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= SymCntW'(MaxSyms))
    else $error("symbol count out of range");

  // a raw mark leaves the line state alone
  a_mark_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (op_q == OP_MARK)) |=> ($stable(level_q) && $stable(run_q)))
    else $error("mark changed line state");

  // loading only ever happens into an empty or emptying shift register
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> !load)
    else $error("pending symbols overwritten");
`endif

endmodule : hdlc_nrzi_bit_stuff_encoder
`default_nettype wire
